// ===== design/hlas_pkg.sv =====
// Shared types and constants for the HTML link attribute scanner.
`default_nettype none

package hlas_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;

    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CH_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_C   = 8'h63;
    localparam logic [BYTE_W-1:0] CH_E   = 8'h65;
    localparam logic [BYTE_W-1:0] CH_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_H   = 8'h68;
    localparam logic [BYTE_W-1:0] CH_I   = 8'h69;
    localparam logic [BYTE_W-1:0] CH_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_O   = 8'h6F;
    localparam logic [BYTE_W-1:0] CH_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CH_S   = 8'h73;
    localparam logic [BYTE_W-1:0] CH_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_EQ  = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_GT  = 8'h3E;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 3'd0,
        KIND_HREF   = 3'd1,
        KIND_SRC    = 3'd2,
        KIND_ACTION = 3'd3,
        KIND_END    = 3'd4
    } token_kind_t;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_H          = 5'd1,
        ST_HR         = 5'd2,
        ST_HRE        = 5'd3,
        ST_HREF       = 5'd4,
        ST_HREF_EQ    = 5'd5,
        ST_HREF_VAL   = 5'd6,
        ST_S          = 5'd7,
        ST_SR         = 5'd8,
        ST_SRC        = 5'd9,
        ST_SRC_EQ     = 5'd10,
        ST_SRC_VAL    = 5'd11,
        ST_A          = 5'd12,
        ST_AC         = 5'd13,
        ST_ACT        = 5'd14,
        ST_ACTI       = 5'd15,
        ST_ACTIO      = 5'd16,
        ST_ACTION     = 5'd17,
        ST_ACTION_EQ  = 5'd18,
        ST_ACTION_VAL = 5'd19
    } scan_state_t;

    typedef struct packed {
        logic        in_value;
        token_kind_t token_kind;
    } scan_result_t;

endpackage

`default_nettype wire

// ===== design/hlas_scan_core.sv =====
// Keyword match state machine: classifies one byte per advance.
`default_nettype none

module hlas_scan_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic [hlas_pkg::BYTE_W-1:0]  cur_byte,
    output hlas_pkg::scan_result_t            result
);

    hlas_pkg::scan_state_t state_reg;
    hlas_pkg::scan_state_t state_next;
    hlas_pkg::scan_state_t start_state;

    always_comb
    begin
        priority if (cur_byte == hlas_pkg::CH_H)
        begin
            start_state = hlas_pkg::ST_H;
        end
        else if (cur_byte == hlas_pkg::CH_S)
        begin
            start_state = hlas_pkg::ST_S;
        end
        else if (cur_byte == hlas_pkg::CH_A)
        begin
            start_state = hlas_pkg::ST_A;
        end
        else
        begin
            start_state = hlas_pkg::ST_IDLE;
        end
    end

    // next state; a mismatch retries the byte as a keyword start
    always_comb
    begin
        state_next = start_state;
        if (cur_byte == hlas_pkg::CH_NUL)
        begin
            state_next = hlas_pkg::ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                hlas_pkg::ST_H:
                    if (cur_byte == hlas_pkg::CH_R) state_next = hlas_pkg::ST_HR;
                hlas_pkg::ST_HR:
                    if (cur_byte == hlas_pkg::CH_E) state_next = hlas_pkg::ST_HRE;
                hlas_pkg::ST_HRE:
                    if (cur_byte == hlas_pkg::CH_F) state_next = hlas_pkg::ST_HREF;
                hlas_pkg::ST_HREF:
                    if (cur_byte == hlas_pkg::CH_EQ) state_next = hlas_pkg::ST_HREF_EQ;
                hlas_pkg::ST_S:
                    if (cur_byte == hlas_pkg::CH_R) state_next = hlas_pkg::ST_SR;
                hlas_pkg::ST_SR:
                    if (cur_byte == hlas_pkg::CH_C) state_next = hlas_pkg::ST_SRC;
                hlas_pkg::ST_SRC:
                    if (cur_byte == hlas_pkg::CH_EQ) state_next = hlas_pkg::ST_SRC_EQ;
                hlas_pkg::ST_A:
                    if (cur_byte == hlas_pkg::CH_C) state_next = hlas_pkg::ST_AC;
                hlas_pkg::ST_AC:
                    if (cur_byte == hlas_pkg::CH_T) state_next = hlas_pkg::ST_ACT;
                hlas_pkg::ST_ACT:
                    if (cur_byte == hlas_pkg::CH_I) state_next = hlas_pkg::ST_ACTI;
                hlas_pkg::ST_ACTI:
                    if (cur_byte == hlas_pkg::CH_O) state_next = hlas_pkg::ST_ACTIO;
                hlas_pkg::ST_ACTIO:
                    if (cur_byte == hlas_pkg::CH_N) state_next = hlas_pkg::ST_ACTION;
                hlas_pkg::ST_ACTION:
                    if (cur_byte == hlas_pkg::CH_EQ) state_next = hlas_pkg::ST_ACTION_EQ;
                hlas_pkg::ST_HREF_EQ, hlas_pkg::ST_HREF_VAL:
                    state_next = (cur_byte == hlas_pkg::CH_GT) ? hlas_pkg::ST_IDLE
                                                               : hlas_pkg::ST_HREF_VAL;
                hlas_pkg::ST_SRC_EQ, hlas_pkg::ST_SRC_VAL:
                    state_next = (cur_byte == hlas_pkg::CH_GT) ? hlas_pkg::ST_IDLE
                                                               : hlas_pkg::ST_SRC_VAL;
                hlas_pkg::ST_ACTION_EQ, hlas_pkg::ST_ACTION_VAL:
                    state_next = (cur_byte == hlas_pkg::CH_GT) ? hlas_pkg::ST_IDLE
                                                               : hlas_pkg::ST_ACTION_VAL;
                default:
                    state_next = start_state;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        result.in_value   = 1'b0;
        result.token_kind = hlas_pkg::KIND_NONE;
        if (cur_byte == hlas_pkg::CH_NUL)
        begin
            result.token_kind = hlas_pkg::KIND_END;
        end
        else
        begin
            unique case (state_reg)
                hlas_pkg::ST_HREF_EQ, hlas_pkg::ST_SRC_EQ, hlas_pkg::ST_ACTION_EQ:
                    result.in_value = (cur_byte != hlas_pkg::CH_GT);
                hlas_pkg::ST_HREF_VAL:
                    if (cur_byte == hlas_pkg::CH_GT) result.token_kind = hlas_pkg::KIND_HREF;
                    else result.in_value = 1'b1;
                hlas_pkg::ST_SRC_VAL:
                    if (cur_byte == hlas_pkg::CH_GT) result.token_kind = hlas_pkg::KIND_SRC;
                    else result.in_value = 1'b1;
                hlas_pkg::ST_ACTION_VAL:
                    if (cur_byte == hlas_pkg::CH_GT) result.token_kind = hlas_pkg::KIND_ACTION;
                    else result.in_value = 1'b1;
                default:
                    result.in_value = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hlas_pkg::ST_IDLE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cur_byte == hlas_pkg::CH_NUL) |=> state_reg == hlas_pkg::ST_IDLE)
        else $error("zero byte did not return the scanner to idle");

    a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (result.token_kind != hlas_pkg::KIND_NONE)
        |=> state_reg == hlas_pkg::ST_IDLE)
        else $error("token close did not return the scanner to idle");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("scan state moved without a beat");

endmodule

`default_nettype wire

// ===== design/html_link_attribute_scanner.sv =====
// Top level of the HTML link attribute scanner: input stage, scan core, result stage.
`default_nettype none

// Takes one text byte per beat and returns one result beat per byte, in order.
// The block accepts a byte in every clock cycle while the output is not stalled.
// Each byte waits in the input stage until the result stage is free; then its result
// is registered and the keyword state register updates. Results carry the byte, an
// in-value flag for bytes after href=, src= or action= up to the closing '>', and a
// token kind on a '>' that closes a non-empty value or on a zero byte, ending the text.

module html_link_attribute_scanner
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] echo_byte
    output logic [3:0]      m_axis_tuser    // [0] in_value, [3:1] token_kind
);

    logic                            in_valid_reg;
    logic [hlas_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                            out_valid_reg;
    logic [hlas_pkg::BYTE_W-1:0]     out_byte_reg;
    hlas_pkg::scan_result_t          out_result_reg;
    hlas_pkg::scan_result_t          core_result;
    logic                            out_free;
    logic                            advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    hlas_scan_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cur_byte (in_byte_reg),
        .result   (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_result_reg.token_kind, out_result_reg.in_value};

    a_end_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_result_reg.token_kind == hlas_pkg::KIND_END)
        |-> m_axis_tdata == hlas_pkg::CH_NUL)
        else $error("end of text reported on a nonzero byte");

    a_close_is_gt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_result_reg.token_kind == hlas_pkg::KIND_HREF
                          || out_result_reg.token_kind == hlas_pkg::KIND_SRC
                          || out_result_reg.token_kind == hlas_pkg::KIND_ACTION)
        |-> m_axis_tdata == hlas_pkg::CH_GT && !out_result_reg.in_value)
        else $error("token close on a byte other than '>'");

    a_value_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result_reg.in_value
        |-> out_result_reg.token_kind == hlas_pkg::KIND_NONE
            && m_axis_tdata != hlas_pkg::CH_GT && m_axis_tdata != hlas_pkg::CH_NUL)
        else $error("value byte carries a token or a delimiter");

    a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while the output drains");

endmodule

`default_nettype wire
